// ----- sv/fufh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fufh_pkg: shared types and constants of the flash update frame handler
// Word formats, command and status codes, sizes of the frame buffer.
// ----------------------------------------------------------------------------
package fufh_pkg;

  // Frame buffer depth (8 .. 128 bytes)
  localparam int RX_BUFFER_BYTES = 64;
  localparam int ADDR_W          = $clog2(RX_BUFFER_BYTES);
  localparam int CNT_W           = $clog2(RX_BUFFER_BYTES + 1);

  // Results per frame are capped; four go to erase/answer/checksum
  localparam int MAX_RESULTS = 32;
  localparam int MAX_WORDS   = MAX_RESULTS - 4;
  localparam int WORD_CNT_W  = $clog2(MAX_WORDS + 1);

  // Frame lengths
  localparam int SHORT_LEN    = 3;  // info, reboot
  localparam int COMMIT_LEN   = 7;  // commit; also push header + checksum
  localparam int DATA_START   = 5;  // first data byte of a push frame

  // Command bytes
  localparam logic [7:0] CMD_INFO   = 8'hf0;
  localparam logic [7:0] CMD_PUSH   = 8'hf1;
  localparam logic [7:0] CMD_COMMIT = 8'hf2;
  localparam logic [7:0] CMD_REBOOT = 8'hf3;

  // Answer heads and status codes
  localparam logic [7:0] HEAD_INFO      = 8'hf1;
  localparam logic [7:0] HEAD_STATUS    = 8'hff;
  localparam logic [7:0] STATUS_OK      = 8'h00;
  localparam logic [7:0] STATUS_BAD_SUM = 8'h01;
  localparam logic [7:0] STATUS_BAD_LEN = 8'h02;
  localparam logic [7:0] STATUS_BAD_ID  = 8'hf0;

  // Result kinds
  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_ERASE  = 2'd2;

  localparam logic [15:0] PAGE_SIZE_RESET = 16'd512;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] flash_address;
    logic [15:0] flash_word;
    logic [7:0]  answer_byte;
    logic        stay_awake;
    logic        reboot_request;
    logic        last;
  } out_word_t;

  // Decoded frame, handed from receiver to sequencer
  typedef struct packed {
    logic                  erase;
    logic [WORD_CNT_W-1:0] words;
    logic [31:0]           addr;
    logic                  info;
    logic [7:0]            status;
    logic                  awake;
    logic                  reboot;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERASE,
    S_W_LO,
    S_W_HI,
    S_W_OUT,
    S_ANS,
    S_SUM_LO,
    S_SUM_HI
  } seq_state_t;

endpackage

// ----- sv/flash_update_frame_handler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_update_frame_handler_top: flash update frame handler
// Receives command frames byte by byte and answers with flash word loads,
// page erase-writes and checksummed answer frames.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per clock while a frame is being received; each
// byte that fits is written to a single-port-write frame RAM and folded into
// the running Fletcher-16-style sum, kept modulo 256. When the byte flagged
// frame_end is accepted the frame is decoded in that same cycle and in_ready
// drops until every result of the frame has been handed to the output
// register. Word loads pass through S_W_LO, S_W_HI and S_W_OUT, because both
// bytes of a word come through the RAM's one read port with registered read
// data. The output register lets the next frame start arriving while the
// last answer byte still waits on out_ready.
// page_size may be written at any time the block is idle; it is read when
// the info answer goes out.
// ----------------------------------------------------------------------------
module flash_update_frame_handler_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fufh_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fufh_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data
);

  logic [15:0]                 page_size;
  logic                        take;
  logic                        wr_en;
  logic [fufh_pkg::ADDR_W-1:0] wr_addr;
  logic [7:0]                  wr_data;
  logic                        rd_en;
  logic [fufh_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                  rd_data;
  logic                        job_valid;
  fufh_pkg::job_t              job;
  logic                        idle;

  // configuration: page size reported by the info command
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= fufh_pkg::PAGE_SIZE_RESET;
    end else if (cfg_we) begin
      page_size <= cfg_data;
    end
  end

  // bytes are taken only while the sequencer has nothing left to send
  assign in_ready = idle;
  assign take     = in_valid && in_ready;

  fufh_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_data   (in_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_valid (job_valid),
    .job       (job)
  );

  // frame store; entries past the frame length are never read
  fufh_ram #(
    .DEPTH (fufh_pkg::RX_BUFFER_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fufh_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .page_size (page_size),
    .idle      (idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sv/fufh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fufh_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fufh_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/fufh_rx.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fufh_rx: frame receiver
// Writes bytes to the frame RAM, keeps the Fletcher-16-style sum (modulo 256)
// and decodes the frame on its last byte.
// ----------------------------------------------------------------------------
module fufh_rx (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  fufh_pkg::in_word_t           in_data,
  output logic                         wr_en,
  output logic [fufh_pkg::ADDR_W-1:0]  wr_addr,
  output logic [7:0]                   wr_data,
  output logic                         job_valid,
  output fufh_pkg::job_t               job
);

  localparam int CW = fufh_pkg::CNT_W;

  logic [CW-1:0] cnt;
  logic          ovf;
  logic [7:0]    sl;
  logic [7:0]    sh;
  logic [7:0]    d1;          // last stored byte
  logic [7:0]    d2;          // byte before it
  logic [7:0]    id;
  logic [31:0]   addr;

  logic          stored_now;
  logic          add_now;
  logic [CW-1:0] len_next;
  logic          ovf_next;
  logic [7:0]    sl_next;
  logic [7:0]    sh_next;
  logic [7:0]    id_next;
  logic          sum_ok;
  logic [CW-1:0] data_len;
  logic [CW-2:0] words;
  logic          known;

  assign stored_now = !ovf && (cnt < CW'(fufh_pkg::RX_BUFFER_BYTES));
  assign add_now    = stored_now && (cnt >= CW'(2));
  assign len_next   = stored_now ? cnt + CW'(1) : cnt;
  assign ovf_next   = ovf || !stored_now;
  assign sl_next    = add_now ? sl + d2 : sl;
  assign sh_next    = add_now ? sh + sl_next : sh;
  assign id_next    = (cnt == CW'(0)) ? in_data.rx_byte : id;
  // checksum bytes are the previous byte and this one
  assign sum_ok     = (d1 == sl_next) && (in_data.rx_byte == sh_next);
  assign data_len   = len_next - CW'(fufh_pkg::COMMIT_LEN);
  assign words      = data_len[CW-1:1];
  assign known      = (id_next == fufh_pkg::CMD_INFO)   || (id_next == fufh_pkg::CMD_PUSH) ||
                      (id_next == fufh_pkg::CMD_COMMIT) || (id_next == fufh_pkg::CMD_REBOOT);

  assign wr_en     = take && stored_now;
  assign wr_addr   = cnt[fufh_pkg::ADDR_W-1:0];
  assign wr_data   = in_data.rx_byte;
  assign job_valid = take && in_data.frame_end;

  always_comb begin
    job        = '0;
    job.addr   = addr;
    job.status = fufh_pkg::STATUS_OK;
    priority if (!known) begin
      job.status = fufh_pkg::STATUS_BAD_ID;
    end else if (ovf_next) begin
      job.status = fufh_pkg::STATUS_BAD_LEN;
    end else if (id_next == fufh_pkg::CMD_INFO || id_next == fufh_pkg::CMD_REBOOT) begin
      if (len_next != CW'(fufh_pkg::SHORT_LEN)) begin
        job.status = fufh_pkg::STATUS_BAD_LEN;
      end else if (!sum_ok) begin
        job.status = fufh_pkg::STATUS_BAD_SUM;
      end else begin
        job.awake  = 1'b1;
        job.info   = (id_next == fufh_pkg::CMD_INFO);
        job.reboot = (id_next == fufh_pkg::CMD_REBOOT);
      end
    end else if (id_next == fufh_pkg::CMD_COMMIT) begin
      if (len_next != CW'(fufh_pkg::COMMIT_LEN)) begin
        job.status = fufh_pkg::STATUS_BAD_LEN;
      end else if (!sum_ok) begin
        job.status = fufh_pkg::STATUS_BAD_SUM;
      end else begin
        job.awake = 1'b1;
        job.erase = 1'b1;
      end
    end else begin
      if (len_next < CW'(fufh_pkg::COMMIT_LEN) || data_len[0] ||
          int'(words) > fufh_pkg::MAX_WORDS) begin
        job.status = fufh_pkg::STATUS_BAD_LEN;
      end else begin
        job.awake = 1'b1;
        if (!sum_ok) begin
          job.status = fufh_pkg::STATUS_BAD_SUM;
        end else begin
          job.words = fufh_pkg::WORD_CNT_W'(words);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
      sl  <= '0;
      sh  <= '0;
    end else if (take) begin
      if (in_data.frame_end) begin
        cnt <= '0;
        ovf <= 1'b0;
        sl  <= '0;
        sh  <= '0;
      end else begin
        cnt <= len_next;
        ovf <= ovf_next;
        sl  <= sl_next;
        sh  <= sh_next;
      end
    end
  end

  // header bytes and delay line for the sum
  always_ff @(posedge clk) begin
    if (take && stored_now) begin
      d2 <= d1;
      d1 <= in_data.rx_byte;
      id <= id_next;
      if (cnt == CW'(1)) begin
        addr[7:0] <= in_data.rx_byte;
      end
      if (cnt == CW'(2)) begin
        addr[15:8] <= in_data.rx_byte;
      end
      if (cnt == CW'(3)) begin
        addr[23:16] <= in_data.rx_byte;
      end
      if (cnt == CW'(4)) begin
        addr[31:24] <= in_data.rx_byte;
      end
    end
  end

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> cnt == CW'(fufh_pkg::RX_BUFFER_BYTES))
    else $error("overflow flag set below full buffer");

  a_cnt_cleared: assert property (@(posedge clk) disable iff (rst)
    job_valid |=> cnt == CW'(0) && !ovf && sl == 8'd0 && sh == 8'd0)
    else $error("frame state not cleared after frame end");

endmodule

// ----- sv/fufh_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fufh_seq: result sequencer
// Emits erase, word loads read from the frame RAM, and the answer frame
// with its Fletcher-16-style sum (modulo 256), through one output register.
// ----------------------------------------------------------------------------
module fufh_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  fufh_pkg::job_t               job,
  input  logic [15:0]                  page_size,
  output logic                         idle,
  output logic                         rd_en,
  output logic [fufh_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [7:0]                   rd_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fufh_pkg::out_word_t          out_data
);

  localparam int AW = fufh_pkg::ADDR_W;
  localparam int WW = fufh_pkg::WORD_CNT_W;

  fufh_pkg::seq_state_t state, state_next;
  fufh_pkg::job_t       job_r;
  fufh_pkg::out_word_t  res;

  logic [WW-1:0] widx;
  logic [AW-1:0] ptr;
  logic [31:0]   waddr;
  logic [7:0]    lo_byte;
  logic [1:0]    midx;
  logic [7:0]    flo;
  logic [7:0]    fhi;
  logic [7:0]    msg;
  logic [1:0]    msg_last;
  logic          slot_free;
  logic          emit;

  function automatic logic [7:0] msg_byte(input logic info, input logic [1:0] idx,
                                          input logic [7:0] status,
                                          input logic [15:0] ps);
    logic [7:0] b;
    if (info) begin
      unique case (idx)
        2'd0:    b = fufh_pkg::HEAD_INFO;
        2'd1:    b = ps[7:0];
        default: b = ps[15:8];
      endcase
    end else begin
      b = (idx == 2'd0) ? fufh_pkg::HEAD_STATUS : status;
    end
    return b;
  endfunction

  assign slot_free = !out_valid || out_ready;
  assign idle      = (state == fufh_pkg::S_IDLE);
  assign msg       = msg_byte(job_r.info, midx, job_r.status, page_size);
  assign msg_last  = job_r.info ? 2'd2 : 2'd1;

  always_comb begin
    state_next         = state;
    emit               = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = ptr;
    res                = '0;
    res.stay_awake     = job_r.awake;
    res.reboot_request = job_r.reboot;
    unique case (state)
      fufh_pkg::S_IDLE: begin
        if (job_valid) begin
          if (job.erase) begin
            state_next = fufh_pkg::S_ERASE;
          end else if (job.words != WW'(0)) begin
            state_next = fufh_pkg::S_W_LO;
          end else begin
            state_next = fufh_pkg::S_ANS;
          end
        end
      end
      fufh_pkg::S_ERASE: begin
        res.kind          = fufh_pkg::KIND_ERASE;
        res.flash_address = job_r.addr;
        if (slot_free) begin
          emit       = 1'b1;
          state_next = fufh_pkg::S_ANS;
        end
      end
      fufh_pkg::S_W_LO: begin
        rd_en      = 1'b1;
        state_next = fufh_pkg::S_W_HI;
      end
      fufh_pkg::S_W_HI: begin
        rd_en      = 1'b1;
        rd_addr    = ptr + AW'(1);
        state_next = fufh_pkg::S_W_OUT;
      end
      fufh_pkg::S_W_OUT: begin
        res.kind          = fufh_pkg::KIND_WORD;
        res.flash_address = waddr;
        res.flash_word    = {rd_data, lo_byte};
        if (slot_free) begin
          emit = 1'b1;
          if (widx + WW'(1) == job_r.words) begin
            state_next = fufh_pkg::S_ANS;
          end else begin
            state_next = fufh_pkg::S_W_LO;
          end
        end
      end
      fufh_pkg::S_ANS: begin
        res.answer_byte = msg;
        if (slot_free) begin
          emit = 1'b1;
          if (midx == msg_last) begin
            state_next = fufh_pkg::S_SUM_LO;
          end
        end
      end
      fufh_pkg::S_SUM_LO: begin
        res.answer_byte = flo;
        if (slot_free) begin
          emit       = 1'b1;
          state_next = fufh_pkg::S_SUM_HI;
        end
      end
      fufh_pkg::S_SUM_HI: begin
        res.answer_byte = fhi;
        res.last        = 1'b1;
        if (slot_free) begin
          emit       = 1'b1;
          state_next = fufh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fufh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fufh_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res;
    end
    if (state == fufh_pkg::S_IDLE && job_valid) begin
      job_r <= job;
      widx  <= '0;
      ptr   <= AW'(fufh_pkg::DATA_START);
      waddr <= job.addr;
      midx  <= '0;
      flo   <= '0;
      fhi   <= '0;
    end
    if (state == fufh_pkg::S_W_HI) begin
      lo_byte <= rd_data;
    end
    if (state == fufh_pkg::S_W_OUT && emit) begin
      widx  <= widx + WW'(1);
      ptr   <= ptr + AW'(2);
      waddr <= waddr + 32'd2;
    end
    if (state == fufh_pkg::S_ANS && emit) begin
      midx <= midx + 2'd1;
      flo  <= flo + msg;
      fhi  <= fhi + flo + msg;
    end
  end

  a_job_when_idle: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> state == fufh_pkg::S_IDLE)
    else $error("frame decoded while results still draining");

  a_word_in_range: assert property (@(posedge clk) disable iff (rst)
    state == fufh_pkg::S_W_LO |-> widx < job_r.words)
    else $error("word load beyond decoded word count");

  a_last_is_answer: assert property (@(posedge clk) disable iff (rst)
    emit && res.last |-> res.kind == fufh_pkg::KIND_ANSWER && state_next == fufh_pkg::S_IDLE)
    else $error("final result is not the answer checksum");

  a_reboot_answer: assert property (@(posedge clk) disable iff (rst)
    emit && res.reboot_request |-> res.kind == fufh_pkg::KIND_ANSWER)
    else $error("reboot flagged on a flash result");

endmodule
